### hw/rtl/lpdf_pkg.sv
// Shared types and constants for the length-prefixed deframer.
package lpdf_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned FRAME_LENGTH_W = 32;
  localparam int unsigned FRAME_INDEX_W  = 8;

  localparam logic [BYTE_W-1:0] MARKER = 8'h7C;  // '|'

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  typedef struct packed {
    logic                      kind;
    logic [BYTE_W-1:0]         payload_byte;
    logic [FRAME_LENGTH_W-1:0] frame_length;
    logic [FRAME_INDEX_W-1:0]  frame_index;
    logic                      is_last;
  } res_t;

endpackage

### hw/rtl/lpdf_in_stage.sv
// Input register for received bytes.
module lpdf_in_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rx_valid,
  input  logic [lpdf_pkg::BYTE_W-1:0] rx_byte,
  output logic                      rx_stall,
  input  logic                      drain_ok,
  output logic                      fire,
  output logic [lpdf_pkg::BYTE_W-1:0] byte_q
);
  import lpdf_pkg::*;

  logic full;
  logic accept;

  assign fire     = full && drain_ok;
  assign rx_stall = full && !drain_ok;
  assign accept   = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (fire) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= rx_byte;
    end
  end

endmodule

### hw/rtl/lpdf_parser.sv
// Frame parser: phase machine, length accumulation and result forming.
module lpdf_parser #(
  parameter int unsigned LENGTH_WIDTH     = 32,
  parameter int unsigned MAX_LENGTH_CHARS = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [lpdf_pkg::BYTE_W-1:0] byte_q,
  output logic                        has_res,
  output lpdf_pkg::res_t              res
);
  import lpdf_pkg::*;

  localparam int unsigned CHAR_W = $clog2(MAX_LENGTH_CHARS + 1);
  localparam int unsigned PROD_W = LENGTH_WIDTH + 4;

  phase_t                    phase, phase_next;
  logic [LENGTH_WIDTH-1:0]   length_accum, length_accum_next;
  logic [CHAR_W-1:0]         length_chars, length_chars_next;
  logic                      digits_stopped, digits_stopped_next;
  logic [LENGTH_WIDTH-1:0]   bytes_remaining, bytes_remaining_next;
  logic [FRAME_INDEX_W-1:0]  frames_done, frames_done_next;

  logic                      is_marker;
  logic                      is_digit;
  logic [PROD_W-1:0]         accum_ext;
  logic [PROD_W-1:0]         times_ten;
  logic [LENGTH_WIDTH-1:0]   accum_sat;
  logic [LENGTH_WIDTH-1:0]   remaining_dec;

  assign is_marker = (byte_q == MARKER);
  assign is_digit  = byte_q inside {[8'h30:8'h39]};

  // accum * 10 + digit as shift-adds; saturate on carry out of LENGTH_WIDTH
  assign accum_ext = PROD_W'(length_accum);
  assign times_ten = (accum_ext << 3) + (accum_ext << 1) + PROD_W'(byte_q[3:0]);
  assign accum_sat = (|times_ten[PROD_W-1:LENGTH_WIDTH]) ? '1
                                                          : times_ten[LENGTH_WIDTH-1:0];
  assign remaining_dec = bytes_remaining - LENGTH_WIDTH'(1);

  always_comb begin
    phase_next           = phase;
    length_accum_next    = length_accum;
    length_chars_next    = length_chars;
    digits_stopped_next  = digits_stopped;
    bytes_remaining_next = bytes_remaining;
    frames_done_next     = frames_done;
    has_res              = 1'b0;
    res.kind             = KIND_HEADER;
    res.payload_byte     = '0;
    res.frame_length     = FRAME_LENGTH_W'(length_accum);
    res.frame_index      = frames_done;
    res.is_last          = 1'b0;

    case (phase)
      PH_LEN: begin
        if (is_marker) begin
          has_res = 1'b1;
          if (length_accum == '0) begin
            res.is_last      = 1'b1;
            frames_done_next = frames_done + FRAME_INDEX_W'(1);
            phase_next       = PH_IDLE;
          end else begin
            bytes_remaining_next = length_accum;
            phase_next           = PH_DATA;
          end
        end else if (length_chars < CHAR_W'(MAX_LENGTH_CHARS)) begin
          length_chars_next = length_chars + CHAR_W'(1);
          if (!digits_stopped) begin
            if (is_digit) begin
              length_accum_next = accum_sat;
            end else begin
              digits_stopped_next = 1'b1;
            end
          end
        end
      end
      PH_DATA: begin
        has_res              = 1'b1;
        bytes_remaining_next = remaining_dec;
        res.kind             = KIND_PAYLOAD;
        res.payload_byte     = byte_q;
        res.is_last          = (remaining_dec == '0);
        if (remaining_dec == '0) begin
          frames_done_next = frames_done + FRAME_INDEX_W'(1);
          phase_next       = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (is_marker) begin
          phase_next           = PH_LEN;
          length_accum_next    = '0;
          length_chars_next    = '0;
          digits_stopped_next  = 1'b0;
          bytes_remaining_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      length_accum    <= '0;
      length_chars    <= '0;
      digits_stopped  <= 1'b0;
      bytes_remaining <= '0;
      frames_done     <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      length_accum    <= length_accum_next;
      length_chars    <= length_chars_next;
      digits_stopped  <= digits_stopped_next;
      bytes_remaining <= bytes_remaining_next;
      frames_done     <= frames_done_next;
    end
  end

endmodule

### hw/rtl/lpdf_out_reg.sv
// Result register driving the output channel.
module lpdf_out_reg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  lpdf_pkg::res_t                      res,
  input  logic                                res_stall,
  output logic                                res_valid,
  output logic                                out_free,
  output logic                                kind,
  output logic [lpdf_pkg::BYTE_W-1:0]         payload_byte,
  output logic [lpdf_pkg::FRAME_LENGTH_W-1:0] frame_length,
  output logic [lpdf_pkg::FRAME_INDEX_W-1:0]  frame_index,
  output logic                                is_last
);
  import lpdf_pkg::*;

  res_t held;

  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign kind         = held.kind;
  assign payload_byte = held.payload_byte;
  assign frame_length = held.frame_length;
  assign frame_index  = held.frame_index;
  assign is_last      = held.is_last;

endmodule

### hw/rtl/ascii_length_prefixed_deframer_core.sv
// Top level of the length-prefixed frame deframer.
//
// Input channel (rx_valid / rx_stall / rx_byte): one raw serial byte per item.
// Output channel (res_valid / res_stall / fields): zero or one result per byte.
// Frames look like '|' <decimal length> '|' <payload>. Bytes outside a frame
// are dropped. The closing '|' of the length gives a header item (kind = 0)
// carrying the parsed length; each payload byte then gives a payload item
// (kind = 1), the final one flagged with is_last. A zero length header has
// is_last set and ends the frame at once.
//
// An accepted byte waits in the input register, then goes through the parser
// into the result register that drives res_valid. Throughput: one byte per
// cycle unless a result waits under res_stall. The input register hands its
// byte to the parser and result register in the same cycle it takes another.
//
// Stall: when res_stall holds a waiting result, the parser pauses and the
// input register keeps one byte; rx_stall rises only while both are full.
// Reset (rst, synchronous): both registers empty, parser back to hunting for
// a marker, frame counter cleared.
module ascii_length_prefixed_deframer_core #(
  parameter int unsigned LENGTH_WIDTH     = 32,
  parameter int unsigned MAX_LENGTH_CHARS = 11
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rx_valid,
  output logic                                rx_stall,
  input  logic [lpdf_pkg::BYTE_W-1:0]         rx_byte,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic                                kind,
  output logic [lpdf_pkg::BYTE_W-1:0]         payload_byte,
  output logic [lpdf_pkg::FRAME_LENGTH_W-1:0] frame_length,
  output logic [lpdf_pkg::FRAME_INDEX_W-1:0]  frame_index,
  output logic                                is_last
);
  import lpdf_pkg::*;

  logic              out_free;   // result register can take a new item
  logic              fire;       // buffered byte goes through the parser
  logic [BYTE_W-1:0] byte_q;
  logic              has_res;
  res_t              res;

  lpdf_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_byte  (rx_byte),
    .rx_stall (rx_stall),
    .drain_ok (out_free),
    .fire     (fire),
    .byte_q   (byte_q)
  );

  lpdf_parser #(
    .LENGTH_WIDTH     (LENGTH_WIDTH),
    .MAX_LENGTH_CHARS (MAX_LENGTH_CHARS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_q  (byte_q),
    .has_res (has_res),
    .res     (res)
  );

  // Only bytes that produce a result fill the output register.
  lpdf_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (fire && has_res),
    .res          (res),
    .res_stall    (res_stall),
    .res_valid    (res_valid),
    .out_free     (out_free),
    .kind         (kind),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .frame_index  (frame_index),
    .is_last      (is_last)
  );

endmodule

### hw/rtl/lpdf_checker.sv
// Port-level checks for the deframer top level, bound in below.
module lpdf_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                rx_stall,
  input logic                                res_valid,
  input logic                                res_stall,
  input logic                                kind,
  input logic [lpdf_pkg::BYTE_W-1:0]         payload_byte,
  input logic [lpdf_pkg::FRAME_LENGTH_W-1:0] frame_length,
  input logic                                is_last
);
  import lpdf_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  a_rx_stall_cause: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> res_valid && res_stall)
    else $error("input stalled without a stalled result");

  a_header_no_payload: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_HEADER |-> payload_byte == '0)
    else $error("header carries payload byte");

  a_empty_header: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_HEADER && is_last |-> frame_length == '0)
    else $error("last header with nonzero length");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind ascii_length_prefixed_deframer_core lpdf_checker u_lpdf_checker (.*);

### tb/ascii_length_prefixed_deframer_core_tb.sv
// Self-checking testbench for the length-prefixed frame deframer core.
module ascii_length_prefixed_deframer_core_tb;
  import lpdf_pkg::*;

  localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] ASCII_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] ASCII_SPACE = 8'h20;

  // Matches the block's default parameters.
  localparam int unsigned MAX_CHARS = 11;

  // Watchdog: cycles with no handshake on either side before giving up.
  localparam int unsigned HANG_LIMIT = 2000;
  // Drain time after the last expected result.
  localparam int unsigned DRAIN_CYCLES = 8;
  // No idling on either side once this few bytes remain to send.
  localparam int unsigned CALM_TAIL = 150;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      rx_valid = 1'b0;
  logic                      rx_stall;
  logic [BYTE_W-1:0]         rx_byte = '0;
  logic                      res_valid;
  logic                      res_stall = 1'b0;
  logic                      kind;
  logic [BYTE_W-1:0]         payload_byte;
  logic [FRAME_LENGTH_W-1:0] frame_length;
  logic [FRAME_INDEX_W-1:0]  frame_index;
  logic                      is_last;

  ascii_length_prefixed_deframer_core dut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .frame_index  (frame_index),
    .is_last      (is_last)
  );

  always #10 clk = ~clk;

  // Serial byte stream still to be sent, and results the deframer owes us.
  logic [BYTE_W-1:0] line_bytes[$];
  res_t              expected_results[$];

  int unsigned total_bytes;
  int unsigned bytes_taken;
  int unsigned frames_built;
  int unsigned headers_seen;
  int unsigned payload_seen;
  int unsigned frames_closed;
  int unsigned mismatches;
  int unsigned rx_gap;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  // ---------------------------------------------------------------------------
  // Deframer shadow state. Length is kept at 32 bits, same as LENGTH_WIDTH.
  // ---------------------------------------------------------------------------
  phase_t                    frame_phase;
  logic [FRAME_LENGTH_W-1:0] parsed_len;
  logic [3:0]                len_chars;
  logic                      len_frozen;
  logic [FRAME_LENGTH_W-1:0] remaining;
  logic [FRAME_INDEX_W-1:0]  frames_done;

  // Advance the shadow deframer by one received byte. Returns 1 when the byte
  // yields a result, which is written to r.
  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output res_t r);
    logic [FRAME_LENGTH_W+3:0] grown;
    bit                        hit;
    hit = 1'b0;
    r   = '0;
    case (frame_phase)
      PH_LEN: begin
        if (b == MARKER) begin
          // Closing marker: header result carries the parsed length.
          hit            = 1'b1;
          r.kind         = KIND_HEADER;
          r.frame_length = parsed_len;
          r.frame_index  = frames_done;
          if (parsed_len == '0) begin
            // Zero length ends the frame right on the header.
            r.is_last   = 1'b1;
            frames_done = frames_done + 1'b1;
            frame_phase = PH_IDLE;
          end else begin
            remaining   = parsed_len;
            frame_phase = PH_DATA;
          end
        end else if (len_chars < MAX_CHARS) begin
          // Characters past the cap are swallowed without effect.
          len_chars = len_chars + 1'b1;
          if (!len_frozen) begin
            if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
              grown = {4'b0, parsed_len} * 36'd10 + 36'(b - ASCII_ZERO);
              parsed_len = (grown > 36'h0_FFFF_FFFF) ? '1 : grown[FRAME_LENGTH_W-1:0];
            end else begin
              // Sign, space or any other non-digit freezes the value.
              len_frozen = 1'b1;
            end
          end
        end
      end
      PH_DATA: begin
        // Markers in the payload are plain data.
        remaining      = remaining - 1'b1;
        hit            = 1'b1;
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        r.frame_length = parsed_len;
        r.frame_index  = frames_done;
        r.is_last      = (remaining == '0);
        if (r.is_last) begin
          frames_done = frames_done + 1'b1;
          frame_phase = PH_IDLE;
        end
      end
      default: begin
        // Hunting: everything but a marker is dropped.
        frame_phase = PH_IDLE;
        if (b == MARKER) begin
          frame_phase = PH_LEN;
          parsed_len  = '0;
          len_chars   = '0;
          len_frozen  = 1'b0;
          remaining   = '0;
        end
      end
    endcase
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------------
  function automatic void push_byte(input logic [BYTE_W-1:0] b);
    line_bytes.push_back(b);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [BYTE_W-1:0] any_but_marker();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == MARKER);
    return b;
  endfunction

  // Non-digit for the length field; signs and spaces come up often.
  function automatic logic [BYTE_W-1:0] length_breaker();
    logic [BYTE_W-1:0] b;
    case ($urandom_range(0, 5))
      0: b = ASCII_PLUS;
      1: b = ASCII_MINUS;
      2: b = ASCII_SPACE;
      default: begin
        do b = any_but_marker(); while (b >= ASCII_ZERO && b <= ASCII_NINE);
      end
    endcase
    return b;
  endfunction

  // One well-formed frame with random content. The length text takes one of
  // several shapes, all of which parse to flen: plain, zero padded, cut short
  // by a non-digit with junk behind it, or filling the character cap with
  // extra digits past it. Zero lengths are common so the frame counter wraps.
  function automatic void add_random_frame();
    int unsigned flen;
    string       digits;
    flen = ($urandom_range(0, 9) < 4) ? 0 :
           (($urandom_range(0, 15) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8));
    digits = $sformatf("%0d", flen);
    repeat ($urandom_range(0, 2)) push_byte(any_but_marker());
    push_byte(MARKER);
    case ($urandom_range(0, 3))
      0: begin
        // Empty length field is a legal zero.
        if (flen != 0 || $urandom_range(0, 1)) push_text(digits);
      end
      1: begin
        repeat ($urandom_range(1, MAX_CHARS - digits.len())) push_byte(ASCII_ZERO);
        push_text(digits);
      end
      2: begin
        push_text(digits);
        push_byte(length_breaker());
        repeat ($urandom_range(0, 12)) push_byte(any_but_marker());
      end
      default: begin
        repeat (MAX_CHARS - digits.len()) push_byte(ASCII_ZERO);
        push_text(digits);
        repeat ($urandom_range(1, 4))
          push_byte(BYTE_W'(ASCII_ZERO + $urandom_range(0, 9)));
      end
    endcase
    push_byte(MARKER);
    repeat (flen) push_byte(BYTE_W'($urandom_range(0, 255)));
    frames_built++;
  endfunction

  // Idling happens in bands, with quiet stretches between, and not at all
  // near the end of the stream.
  function automatic bit idling_allowed();
    return line_bytes.size() > CALM_TAIL && ((line_bytes.size() / 97) % 3 != 0);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: takes the next byte once the current one is accepted, with random
  // gaps. A byte that sits under rx_stall is held unchanged.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t r;
    if (rst) begin
      rx_valid    <= 1'b0;
      rx_gap       = 0;
      frame_phase  = PH_IDLE;
      parsed_len   = '0;
      len_chars    = '0;
      len_frozen   = 1'b0;
      remaining    = '0;
      frames_done  = '0;
    end else begin
      if (rx_valid && !rx_stall) begin
        bytes_taken++;
        if (deframe_byte(rx_byte, r)) expected_results.push_back(r);
      end
      if (!rx_valid || !rx_stall) begin
        if (rx_gap == 0 && idling_allowed() && $urandom_range(0, 7) == 0)
          rx_gap = $urandom_range(1, 9);
        if (rx_gap != 0 || line_bytes.size() == 0) begin
          rx_valid <= 1'b0;
          if (rx_gap != 0) rx_gap--;
        end else begin
          rx_valid <= 1'b1;
          rx_byte  <= line_bytes.pop_front();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest expectation and
  // throws random stall bursts at the result channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0h byte %0h",
                   $time, kind, payload_byte);
          $display("%0t:   len %0h idx %0h last %0h",
                   $time, frame_length, frame_index, is_last);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
          check_field("frame_length", want.frame_length, frame_length);
          check_field("frame_index", 32'(want.frame_index), 32'(frame_index));
          check_field("is_last", 32'(want.is_last), 32'(is_last));
          if (want.kind == KIND_HEADER) headers_seen++;
          else payload_seen++;
          if (want.is_last) frames_closed++;
        end
      end
      if (stall_left == 0 && idling_allowed() && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 9);
      if (stall_left != 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // Watchdog: a long stretch with no handshake on either side means a hang.
  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
        $display("ascii_length_prefixed_deframer_core verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    // Directed: idle noise, empty and zero lengths, extreme payload bytes with
    // a marker inside the payload, freezes on sign and space, and the cap.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("A");
    push_text("||");
    push_text("|0|");
    push_text("|3|");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(MARKER);
    push_text("|2+7|");
    push_byte(8'hAA);
    push_byte(8'h55);
    push_text("|-4|");
    push_text("| 1|");
    push_text("|000000000012|");  // 12th char past the cap: length is 1
    push_byte(8'h7E);

    // A run of empty frames wraps the frame index cheaply.
    repeat (256) push_text("||");

    // Random frames fill out the rest of the stream.
    while (line_bytes.size() < 1280) add_random_frame();

    // Saturating length goes last since its payload can never finish.
    push_text("|42949672959|");
    repeat (3) push_byte(BYTE_W'($urandom_range(0, 255)));
    total_bytes = line_bytes.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken < total_bytes || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes: directed frames, 256 empty frames, %0d random frames.",
             bytes_taken, frames_built);
    $display("Checked %0d headers and %0d payload bytes; frames closed: %0d, mismatches: %0d.",
             headers_seen, payload_seen, frames_closed, mismatches);
    if (mismatches == 0) begin
      $display("ascii_length_prefixed_deframer_core verification clean");
    end else begin
      $display("ascii_length_prefixed_deframer_core verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/lpdf_pkg.sv
hw/rtl/lpdf_in_stage.sv
hw/rtl/lpdf_parser.sv
hw/rtl/lpdf_out_reg.sv
hw/rtl/ascii_length_prefixed_deframer_core.sv
hw/rtl/lpdf_checker.sv
tb/ascii_length_prefixed_deframer_core_tb.sv
